/* rtl/cpsat_pkg.sv */
// Shared constants and types for the polygon collision block.
package cpsat_pkg;
  localparam int MAX_VERTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W = $clog2(MAX_VERTS);
  localparam int CNT_W = $clog2(MAX_VERTS + 1);
  localparam int AX_W = COORD_BITS + 1;
  localparam int PROD_W = COORD_BITS + AX_W;
  localparam int PROJ_W = PROD_W + 1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FEW = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] count_a;
    logic [CNT_W-1:0] count_b;
    logic [1:0] status;
  } job_t;
endpackage

/* rtl/cpsat_front.sv */
// Front end: stores vertices, counts them, queues one job per polygon pair.
module cpsat_front import cpsat_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic poly,
  input  logic signed [COORD_BITS-1:0] vert_x,
  input  logic signed [COORD_BITS-1:0] vert_y,
  input  logic last,
  output logic wr_en,
  output logic wr_poly,
  output logic [IDX_W-1:0] wr_addr,
  output logic [2*COORD_BITS-1:0] wr_data,
  output logic job_valid,
  output job_t job,
  input  logic job_take
);
  logic [CNT_W-1:0] count_a, count_b;
  logic overflow_flag;
  logic acc, full_sel, close;
  logic [CNT_W-1:0] ca_next, cb_next;
  logic ovf_next;

  // one pending job at a time; loading holds while the back end still reads stores
  assign in_stall = job_valid;
  assign acc = in_valid && !in_stall;
  assign full_sel = poly ? (count_b == CNT_W'(MAX_VERTS)) : (count_a == CNT_W'(MAX_VERTS));
  assign close = acc && last && poly;
  assign wr_en = acc && !full_sel;
  assign wr_poly = poly;
  assign wr_addr = poly ? count_b[IDX_W-1:0] : count_a[IDX_W-1:0];
  assign wr_data = {vert_x, vert_y};

  always_comb begin
    ca_next = count_a + CNT_W'(wr_en && !poly);
    cb_next = count_b + CNT_W'(wr_en && poly);
    ovf_next = overflow_flag || (acc && full_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
      overflow_flag <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (job_take) job_valid <= 1'b0;
      if (close) begin
        job_valid <= 1'b1;
        job.count_a <= ca_next;
        job.count_b <= cb_next;
        if (ovf_next) job.status <= ST_OVF;
        else if (ca_next < CNT_W'(3) || cb_next < CNT_W'(3)) job.status <= ST_FEW;
        else job.status <= ST_OK;
        count_a <= '0;
        count_b <= '0;
        overflow_flag <= 1'b0;
      end else begin
        count_a <= ca_next;
        count_b <= cb_next;
        overflow_flag <= ovf_next;
      end
    end
  end
endmodule

/* rtl/cpsat_back.sv */
// Back end: vertex memories and the axis-by-vertex separation sequencer.
module cpsat_back import cpsat_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic wr_poly,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [2*COORD_BITS-1:0] wr_data,
  input  logic job_valid,
  input  job_t job,
  output logic job_take,
  output logic out_valid,
  input  logic out_stall,
  output logic collide,
  output logic [1:0] status
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_EA = 6'b000010, S_EB = 6'b000100,
    S_PROJ = 6'b001000, S_CMP = 6'b010000, S_OUT = 6'b100000
  } state_t;

  logic [2*COORD_BITS-1:0] mem_a [MAX_VERTS];
  logic [2*COORD_BITS-1:0] mem_b [MAX_VERTS];
  logic [2*COORD_BITS-1:0] rd_a, rd_b;
  logic [IDX_W-1:0] ra_addr, rb_addr;

  state_t state;
  logic ax_poly;
  logic [CNT_W-1:0] ax_i, vi;
  logic vsel, pv;
  logic signed [COORD_BITS-1:0] ux, uy;
  logic signed [AX_W-1:0] nx, ny;
  logic signed [PROD_W-1:0] px, py;
  logic p_valid, p_sel;
  logic signed [PROJ_W-1:0] alo, ahi, blo, bhi, s;
  logic a_init, b_init;
  logic [CNT_W-1:0] n_ax, n_v, next_i, vnext;

  always_ff @(posedge clk) begin
    if (wr_en && !wr_poly) mem_a[wr_addr] <= wr_data;
    if (wr_en && wr_poly) mem_b[wr_addr] <= wr_data;
    rd_a <= mem_a[ra_addr];
    rd_b <= mem_b[rb_addr];
  end

  assign n_ax = ax_poly ? job.count_b : job.count_a;
  assign n_v = vsel ? job.count_b : job.count_a;
  assign next_i = (ax_i + CNT_W'(1) == n_ax) ? '0 : ax_i + CNT_W'(1);
  assign vnext = (vi + CNT_W'(1) == n_v) ? '0 : vi + CNT_W'(1);

  // read address runs ahead of the vertex being consumed, by the registered memory read
  always_comb begin
    ra_addr = vi[IDX_W-1:0];
    if (state == S_EA) begin
      ra_addr = ax_i[IDX_W-1:0];
    end else if (state == S_EB) begin
      ra_addr = next_i[IDX_W-1:0];
    end else if (state == S_PROJ && pv) begin
      ra_addr = vnext[IDX_W-1:0];
    end
    rb_addr = ra_addr;
  end

  assign s = PROJ_W'(px) + PROJ_W'(py);
  assign job_take = (state == S_OUT) && !out_stall;
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      p_valid <= 1'b0;
    end else begin
      p_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          ax_poly <= 1'b0;
          ax_i <= '0;
          if (job_valid) begin
            if (job.status != ST_OK) begin
              collide <= 1'b0;
              status <= job.status;
              state <= S_OUT;
            end else state <= S_EA;
          end
        end
        S_EA: state <= S_EB;
        S_EB: begin
          ux <= ax_poly ? $signed(rd_b[2*COORD_BITS-1:COORD_BITS])
                        : $signed(rd_a[2*COORD_BITS-1:COORD_BITS]);
          uy <= ax_poly ? $signed(rd_b[COORD_BITS-1:0]) : $signed(rd_a[COORD_BITS-1:0]);
          state <= S_PROJ;
          vi <= '0;
          vsel <= 1'b0;
          pv <= 1'b0;
          a_init <= 1'b1;
          b_init <= 1'b1;
        end
        S_PROJ: begin
          if (!pv) begin
            nx <= AX_W'(uy) - AX_W'(ax_poly ? $signed(rd_b[COORD_BITS-1:0])
                                            : $signed(rd_a[COORD_BITS-1:0]));
            ny <= AX_W'(ax_poly ? $signed(rd_b[2*COORD_BITS-1:COORD_BITS])
                                : $signed(rd_a[2*COORD_BITS-1:COORD_BITS])) - AX_W'(ux);
            pv <= 1'b1;
          end else begin
            p_valid <= 1'b1;
            p_sel <= vsel;
            if (vi + CNT_W'(1) == n_v) begin
              vi <= '0;
              if (vsel) state <= S_CMP;
              vsel <= 1'b1;
            end else vi <= vi + CNT_W'(1);
            px <= PROD_W'(vsel ? $signed(rd_b[2*COORD_BITS-1:COORD_BITS])
                               : $signed(rd_a[2*COORD_BITS-1:COORD_BITS])) * PROD_W'(nx);
            py <= PROD_W'(vsel ? $signed(rd_b[COORD_BITS-1:0])
                               : $signed(rd_a[COORD_BITS-1:0])) * PROD_W'(ny);
          end
        end
        S_CMP: begin
          if (!p_valid) begin
            if (ahi < blo || bhi < alo) begin
              collide <= 1'b0;
              status <= ST_OK;
              state <= S_OUT;
            end else if (ax_i + CNT_W'(1) == n_ax) begin
              if (ax_poly) begin
                collide <= 1'b1;
                status <= ST_OK;
                state <= S_OUT;
              end else begin
                ax_poly <= 1'b1;
                ax_i <= '0;
                state <= S_EA;
              end
            end else begin
              ax_i <= ax_i + CNT_W'(1);
              state <= S_EA;
            end
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (p_valid) begin
        if (!p_sel) begin
          if (a_init || s < alo) alo <= s;
          if (a_init || s > ahi) ahi <= s;
          a_init <= 1'b0;
        end else begin
          if (b_init || s < blo) blo <= s;
          if (b_init || s > bhi) bhi <= s;
          b_init <= 1'b0;
        end
      end
    end
  end
endmodule

/* rtl/convex_polygon_sat_collision.sv */
// Top level of the convex polygon separating-axis collision block.
// Input channel: one vertex per item (poly, vert_x, vert_y, last), polygon 0
// then polygon 1. An item with last and poly = 1 closes the pair and yields
// one verdict item (collide, status) on the output channel.
// Loading accepts one vertex per cycle while the input is not stalled. The test
// walks the edges of both polygons until one gives a separating axis; per axis
// it projects every vertex of both polygons through one multiply pair.
// While a pair is tested the input is stalled; vertex stores are shared.
// Errors (overflow, fewer than three vertices) skip the test and go straight to the verdict.
// Reset clears counts, flags and sequencer; vertex memories keep contents.
// The verdict holds on the output while stall is high.
module convex_polygon_sat_collision import cpsat_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic poly,
  input  logic signed [COORD_BITS-1:0] vert_x,
  input  logic signed [COORD_BITS-1:0] vert_y,
  input  logic last,
  output logic out_valid,
  input  logic out_stall,
  output logic collide,
  output logic [1:0] status
);
  logic wr_en, wr_poly, job_valid, job_take;
  logic [IDX_W-1:0] wr_addr;
  logic [2*COORD_BITS-1:0] wr_data;
  job_t job;

  cpsat_front u_front (.*);
  cpsat_back u_back (.*);
endmodule

/* rtl/cpsat_checker.sv */
// Port-level checker for the collision block, bound to the top level.
module cpsat_checker import cpsat_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic collide,
  input logic [1:0] status
);
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_FEW || status == ST_OVF))
    else $error("bad status");
  a_err_nocol: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> !collide)
    else $error("collide with error");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(collide) && $stable(status)))
    else $error("verdict dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open during verdict");
endmodule

bind convex_polygon_sat_collision cpsat_checker u_chk (.*);
